// ===== rtl/core/ws_pkg.sv =====
// shared types and constants for the ws2812 symbol encoder
package ws_pkg;

    localparam int TicksW = 15;
    localparam int LenW   = 13;
    localparam int PosW   = 12;
    localparam int ColorW = 24;
    localparam int IdxW   = 5;
    localparam int CfgIdxW = 3;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] RegOneHigh   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegOneLow    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegZeroHigh  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegZeroLow   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegResetHigh = 3'd4;
    localparam logic [CfgIdxW-1:0] RegResetLow  = 3'd5;
    localparam logic [CfgIdxW-1:0] RegStripLen  = 3'd6;

    // register reset values
    localparam logic [TicksW-1:0] OneHighRst   = 15'd16;
    localparam logic [TicksW-1:0] OneLowRst    = 15'd9;
    localparam logic [TicksW-1:0] ZeroHighRst  = 15'd9;
    localparam logic [TicksW-1:0] ZeroLowRst   = 15'd16;
    localparam logic [TicksW-1:0] ResetHighRst = 15'd1;
    localparam logic [TicksW-1:0] ResetLowRst  = 15'd1000;
    localparam logic [LenW-1:0]   StripLenRst  = 13'd147;

    // symbol positions within one color word
    localparam logic [IdxW-1:0] LastBitIdx = 5'd23;
    localparam logic [IdxW-1:0] ResetIdx   = 5'd24;

    typedef struct packed {
        logic [TicksW-1:0] one_high;
        logic [TicksW-1:0] one_low;
        logic [TicksW-1:0] zero_high;
        logic [TicksW-1:0] zero_low;
        logic [TicksW-1:0] reset_high;
        logic [TicksW-1:0] reset_low;
        logic [LenW-1:0]   strip_len;
    } cfg_t;

    typedef struct packed {
        logic [TicksW-1:0] high_ticks;
        logic [TicksW-1:0] low_ticks;
        logic              frame_end;
        logic              last;
    } sym_t;

endpackage

// ===== rtl/core/ws_cfg_regs.sv =====
// configuration register file for the symbol timings and strip length
module ws_cfg_regs
    import ws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [TicksW-1:0]  cfg_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_high   <= OneHighRst;
            cfg_reg.one_low    <= OneLowRst;
            cfg_reg.zero_high  <= ZeroHighRst;
            cfg_reg.zero_low   <= ZeroLowRst;
            cfg_reg.reset_high <= ResetHighRst;
            cfg_reg.reset_low  <= ResetLowRst;
            cfg_reg.strip_len  <= StripLenRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegOneHigh:   cfg_reg.one_high   <= cfg_data;
                RegOneLow:    cfg_reg.one_low    <= cfg_data;
                RegZeroHigh:  cfg_reg.zero_high  <= cfg_data;
                RegZeroLow:   cfg_reg.zero_low   <= cfg_data;
                RegResetHigh: cfg_reg.reset_high <= cfg_data;
                RegResetLow:  cfg_reg.reset_low  <= cfg_data;
                RegStripLen:  cfg_reg.strip_len  <= cfg_data[LenW-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/ws_sym_gen.sv =====
// input register, bit walker and led position counter
module ws_sym_gen
    import ws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              color_valid,
    output logic              color_ready,
    input  logic [ColorW-1:0] color_word,
    output logic              sym_valid,
    input  logic              sym_ready,
    output sym_t              sym
);

    logic              busy_reg, busy_next;
    logic [ColorW-1:0] word_reg, word_next;
    logic [IdxW-1:0]   idx_reg, idx_next;
    logic              fdone_reg, fdone_next;
    logic [PosW-1:0]   pos_reg, pos_next;

    logic              accept;
    logic              advance;
    logic [LenW-1:0]   pos_inc;
    logic              frame_done;
    logic              is_reset;

    // current symbol from the head of the shifted word, or the reset symbol at frame end
    always_comb
    begin
        is_reset = (idx_reg == ResetIdx);
        if (is_reset)
        begin
            sym.high_ticks = cfg.reset_high;
            sym.low_ticks  = cfg.reset_low;
        end
        else if (word_reg[ColorW-1])
        begin
            sym.high_ticks = cfg.one_high;
            sym.low_ticks  = cfg.one_low;
        end
        else
        begin
            sym.high_ticks = cfg.zero_high;
            sym.low_ticks  = cfg.zero_low;
        end
        sym.frame_end = is_reset;
        sym.last      = is_reset || ((idx_reg == LastBitIdx) && !fdone_reg);
    end

    assign sym_valid   = busy_reg;
    assign advance     = busy_reg && sym_ready;
    assign color_ready = !busy_reg || (sym_ready && sym.last);
    assign accept      = color_valid && color_ready;

    // frame end test on the incremented position, or on a zero strip length
    assign pos_inc    = {1'b0, pos_reg} + 13'd1;
    assign frame_done = (cfg.strip_len == '0) || (pos_inc >= cfg.strip_len);

    // next-state selection
    always_comb
    begin
        busy_next  = busy_reg;
        word_next  = word_reg;
        idx_next   = idx_reg;
        fdone_next = fdone_reg;
        pos_next   = pos_reg;
        priority if (accept)
        begin
            busy_next  = 1'b1;
            word_next  = color_word;
            idx_next   = '0;
            fdone_next = frame_done;
            pos_next   = frame_done ? '0 : pos_inc[PosW-1:0];
        end
        else if (advance)
        begin
            if (sym.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                word_next = {word_reg[ColorW-2:0], 1'b0};
                idx_next  = IdxW'(idx_reg + 5'd1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        idx_reg   <= idx_next;
        fdone_reg <= fdone_next;
    end

endmodule

// ===== rtl/core/ws_out_reg.sv =====
// result register between the symbol walker and the output channel
module ws_out_reg
    import ws_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic sym_valid,
    output logic sym_ready,
    input  sym_t sym,
    output logic out_valid,
    input  logic out_ready,
    output sym_t out_sym
);

    logic valid_reg, valid_next;
    sym_t sym_reg;

    assign sym_ready  = !valid_reg || out_ready;
    assign valid_next = sym_ready ? sym_valid : valid_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload loads on every transfer into the register
    always_ff @(posedge clk)
    begin
        if (sym_ready && sym_valid)
        begin
            sym_reg <= sym;
        end
    end

    assign out_valid = valid_reg;
    assign out_sym   = sym_reg;

endmodule

// ===== rtl/core/ws2812_symbol_encoder.sv =====
// top level: color word in, one pulse symbol per cycle out while the receiver takes them
// the first symbol of a word passes the word register, then enters the output register once it is free
// one symbol per cycle while the output is not stalled; 24 symbols per word, 25 on a word that ends a frame
// the next word is taken in the cycle its predecessor's last symbol moves to the output register
// reset: asynchronous active low, clears led position and valid flags, loads default timings
// a new word is taken while the previous last symbol still waits at the output
module ws2812_symbol_encoder
    import ws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [TicksW-1:0]  cfg_data,
    input  logic               color_valid,
    output logic               color_ready,
    input  logic [ColorW-1:0]  color_word,
    output logic               symbol_valid,
    input  logic               symbol_ready,
    output logic [TicksW-1:0]  high_ticks,
    output logic [TicksW-1:0]  low_ticks,
    output logic               frame_end,
    output logic               last
);

    cfg_t cfg;
    sym_t sym;
    sym_t out_sym;
    logic sym_valid;
    logic sym_ready;

    ws_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ws_sym_gen u_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .color_valid (color_valid),
        .color_ready (color_ready),
        .color_word  (color_word),
        .sym_valid   (sym_valid),
        .sym_ready   (sym_ready),
        .sym         (sym)
    );

    ws_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym       (sym),
        .out_valid (symbol_valid),
        .out_ready (symbol_ready),
        .out_sym   (out_sym)
    );

    assign high_ticks = out_sym.high_ticks;
    assign low_ticks  = out_sym.low_ticks;
    assign frame_end  = out_sym.frame_end;
    assign last       = out_sym.last;

endmodule

// ===== rtl/core/ws_checker.sv =====
// port-level checks for the ws2812 symbol encoder, bound to the top level
module ws_checker
    import ws_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              color_valid,
    input logic              color_ready,
    input logic              symbol_valid,
    input logic              symbol_ready,
    input logic [TicksW-1:0] high_ticks,
    input logic [TicksW-1:0] low_ticks,
    input logic              frame_end,
    input logic              last
);

    // a frame reset symbol always closes its word
    a_fe_last: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && frame_end |-> last)
        else $error("frame end symbol without last");

    // a word in flight blocks the input for at least the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_ready |=> !color_ready)
        else $error("input ready right after a word transfer");

    // a word transfer is followed by a valid symbol at the output
    a_sym_follows: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_ready |-> ##2 symbol_valid)
        else $error("no symbol after a word transfer");

    // a stalled symbol holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && !symbol_ready |=> symbol_valid && $stable(high_ticks)
            && $stable(low_ticks) && $stable(frame_end) && $stable(last))
        else $error("stalled symbol changed");

endmodule

bind ws2812_symbol_encoder ws_checker u_ws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .color_valid  (color_valid),
    .color_ready  (color_ready),
    .symbol_valid (symbol_valid),
    .symbol_ready (symbol_ready),
    .high_ticks   (high_ticks),
    .low_ticks    (low_ticks),
    .frame_end    (frame_end),
    .last         (last)
);

// ===== tb/testbench.sv =====
// testbench for the ws2812 symbol encoder: scoreboard prediction of pulse symbols
`timescale 1ns / 1ps

module testbench;
    import ws_pkg::*;

    localparam int HoldCycles   = 400;
    localparam int SettleCycles = 6;
    localparam int DrainLimit   = 6000;
    localparam int CycleLimit   = 600000;

    // index with no register behind it, writes must be ignored
    localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

    // predicted symbols per color word, checked in order of arrival
    class symbol_scoreboard;
        cfg_t            timing;
        logic [PosW-1:0] led_pos;
        sym_t            expected_symbols[$];
        int              errors;

        function new();
            timing.one_high   = OneHighRst;
            timing.one_low    = OneLowRst;
            timing.zero_high  = ZeroHighRst;
            timing.zero_low   = ZeroLowRst;
            timing.reset_high = ResetHighRst;
            timing.reset_low  = ResetLowRst;
            timing.strip_len  = StripLenRst;
            led_pos = '0;
            errors = 0;
        endfunction

        // register write as the block applies it
        function void write_reg(logic [CfgIdxW-1:0] idx, logic [TicksW-1:0] data);
            case (idx)
                RegOneHigh:   timing.one_high   = data;
                RegOneLow:    timing.one_low    = data;
                RegZeroHigh:  timing.zero_high  = data;
                RegZeroLow:   timing.zero_low   = data;
                RegResetHigh: timing.reset_high = data;
                RegResetLow:  timing.reset_low  = data;
                RegStripLen:  timing.strip_len  = data[LenW-1:0];
                default:      ;
            endcase
        endfunction

        // one accepted color word: 24 bit symbols, plus the reset symbol at frame end
        function void note_color(logic [ColorW-1:0] word);
            logic [PosW:0] next_pos;
            logic          ends_frame;
            sym_t          s;
            int            i;
            next_pos = {1'b0, led_pos} + 1'b1;
            ends_frame = (timing.strip_len == '0) || (next_pos >= timing.strip_len);
            for (i = ColorW - 1; i >= 0; i--)
            begin
                s.high_ticks = word[i] ? timing.one_high : timing.zero_high;
                s.low_ticks  = word[i] ? timing.one_low  : timing.zero_low;
                s.frame_end  = 1'b0;
                s.last       = (i == 0) && !ends_frame;
                expected_symbols.push_back(s);
            end
            if (ends_frame)
            begin
                s.high_ticks = timing.reset_high;
                s.low_ticks  = timing.reset_low;
                s.frame_end  = 1'b1;
                s.last       = 1'b1;
                expected_symbols.push_back(s);
                led_pos = '0;
            end
            else
            begin
                led_pos = next_pos[PosW-1:0];
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // compare one symbol transfer with the oldest prediction
        task check_symbol(logic [TicksW-1:0] hi, logic [TicksW-1:0] lo, logic fe, logic lst);
            sym_t want;
            if (expected_symbols.size() == 0)
            begin
                report_mismatch($sformatf("symbol %0d/%0d fe=%0b last=%0b with none expected",
                                          hi, lo, fe, lst));
                return;
            end
            want = expected_symbols.pop_front();
            if (hi !== want.high_ticks)
                report_mismatch($sformatf("high_ticks %0d, want %0d", hi, want.high_ticks));
            if (lo !== want.low_ticks)
                report_mismatch($sformatf("low_ticks %0d, want %0d", lo, want.low_ticks));
            if (fe !== want.frame_end)
                report_mismatch($sformatf("frame_end %0b, want %0b", fe, want.frame_end));
            if (lst !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", lst, want.last));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [TicksW-1:0]  cfg_data;
    logic               color_valid;
    logic               color_ready;
    logic [ColorW-1:0]  color_word;
    logic               symbol_valid;
    logic               symbol_ready;
    logic [TicksW-1:0]  high_ticks;
    logic [TicksW-1:0]  low_ticks;
    logic               frame_end;
    logic               last;

    symbol_scoreboard   sb = new();
    logic [ColorW-1:0]  words_to_send[$];
    bit                 hold_request = 1'b0;
    int                 cycle_count = 0;

    ws2812_symbol_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .color_valid  (color_valid),
        .color_ready  (color_ready),
        .color_word   (color_word),
        .symbol_valid (symbol_valid),
        .symbol_ready (symbol_ready),
        .high_ticks   (high_ticks),
        .low_ticks    (low_ticks),
        .frame_end    (frame_end),
        .last         (last)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // symbol transfers go to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && symbol_valid === 1'b1 && symbol_ready === 1'b1)
            sb.check_symbol(high_ticks, low_ticks, frame_end, last);
    end

    // receiver: rotating stall pattern, changed now and then, plus long hold-offs on request
    initial
    begin
        int         mode_left;
        logic [7:0] pattern;
        mode_left = 0;
        pattern = 8'hFF;
        symbol_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                symbol_ready <= 1'b0;
                hold_request = 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    case ($urandom_range(0, 4))
                        0, 1:    pattern = 8'hFF;
                        2:       pattern = 8'h01;
                        3:       pattern = 8'hAA;
                        default: pattern = 8'($urandom_range(0, 255)) | 8'h01;
                    endcase
                    mode_left = $urandom_range(20, 150);
                end
                symbol_ready <= pattern[0];
                pattern = {pattern[0], pattern[7:1]};
                mode_left--;
            end
        end
    end

    function automatic logic [TicksW-1:0] pick_ticks();
        logic [TicksW-1:0] t;
        case ($urandom_range(0, 5))
            0:       t = '0;
            1:       t = '1;
            2, 3:    t = TicksW'($urandom_range(1, 40));
            default: t = TicksW'($urandom_range(0, 32767));
        endcase
        return t;
    endfunction

    function automatic logic [ColorW-1:0] pick_word();
        logic [ColorW-1:0] w;
        case ($urandom_range(0, 7))
            0:       w = '0;
            1:       w = '1;
            2:       w = ColorW'(1) << $urandom_range(0, ColorW - 1);
            3:       w = ~(ColorW'(1) << $urandom_range(0, ColorW - 1));
            default: w = ColorW'($urandom_range(0, 24'hFFFFFF));
        endcase
        return w;
    endfunction

    function automatic cfg_t random_timing(logic [LenW-1:0] len);
        cfg_t c;
        c.one_high   = pick_ticks();
        c.one_low    = pick_ticks();
        c.zero_high  = pick_ticks();
        c.zero_low   = pick_ticks();
        c.reset_high = pick_ticks();
        c.reset_low  = pick_ticks();
        c.strip_len  = len;
        return c;
    endfunction

    // color word transfers in bursts with random gaps; valid stays up across a burst
    task automatic send_words();
        logic [ColorW-1:0] w;
        int                burst;
        int                gap;
        while (words_to_send.size() > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && words_to_send.size() > 0)
            begin
                w = words_to_send.pop_front();
                color_valid <= 1'b1;
                color_word  <= w;
                do @(posedge clk); while (color_ready !== 1'b1);
                sb.note_color(w);
                burst--;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(20, 40);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0 && words_to_send.size() > 0)
            begin
                color_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        color_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_random(int count);
        repeat (count) words_to_send.push_back(pick_word());
    endtask

    // wait for every predicted symbol, then let the pipeline settle
    task automatic wait_idle();
        int waited;
        waited = 0;
        while (sb.expected_symbols.size() != 0 && waited < DrainLimit)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    // write all registers while idle; strip length carries junk in its upper bits
    task automatic reprogram(cfg_t c);
        logic [CfgIdxW-1:0] regs[7];
        logic [TicksW-1:0]  vals[7];
        logic [1:0]         junk;
        logic [TicksW-1:0]  stray;
        int                 k;
        junk = 2'($urandom_range(0, 3));
        stray = TicksW'($urandom_range(0, 32767));
        regs = '{RegOneHigh, RegOneLow, RegZeroHigh, RegZeroLow,
                 RegResetHigh, RegResetLow, RegStripLen};
        vals = '{c.one_high, c.one_low, c.zero_high, c.zero_low,
                 c.reset_high, c.reset_low, {junk, c.strip_len}};
        wait_idle();
        for (k = 0; k < 7; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            sb.write_reg(regs[k], vals[k]);
        end
        cfg_index <= RegUnused;
        cfg_data  <= stray;
        @(posedge clk);
        sb.write_reg(RegUnused, stray);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        cfg_t c;
        int   p;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        color_valid = 1'b0;
        color_word  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timings: field extremes and bit patterns
        words_to_send = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h000001, 24'hAAAAAA,
                          24'h555555, 24'hF0F0F0, 24'h0F0F0F, 24'hFF0000, 24'h00FF00,
                          24'h0000FF, 24'h7FFFFF, 24'hFFFFFE, 24'h123456};
        send_words();

        // reset timings through the first frame end, with a long output stall
        hold_request = 1'b1;
        queue_random(140);
        send_words();

        // all timings zero, strip length zero ends a frame on every word
        c = '{'0, '0, '0, '0, '0, '0, '0};
        reprogram(c);
        queue_random(10);
        send_words();

        // all timings at maximum, strip length one
        c = '{'1, '1, '1, '1, '1, '1, 13'd1};
        reprogram(c);
        queue_random(10);
        send_words();

        // strip length shortened below the position: next word ends the frame
        c = random_timing(13'd10);
        reprogram(c);
        queue_random(6);
        send_words();
        c = sb.timing;
        c.strip_len = 13'd3;
        reprogram(c);
        queue_random(8);
        send_words();

        // largest strip lengths, no frame end within reach
        reprogram(random_timing(13'd4096));
        queue_random(8);
        send_words();
        reprogram(random_timing('1));
        queue_random(8);
        send_words();

        // random settings, mostly short strips
        for (p = 0; p < 5; p++)
        begin
            if ($urandom_range(0, 3) == 0)
                c = random_timing(LenW'($urandom_range(0, 8191)));
            else
                c = random_timing(LenW'($urandom_range(0, 8)));
            reprogram(c);
            if (p == 2)
                hold_request = 1'b1;
            queue_random(22);
            send_words();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (sb.expected_symbols.size() != 0)
            sb.report_mismatch($sformatf("%0d symbols never arrived",
                                         sb.expected_symbols.size()));
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ws_pkg.sv
rtl/core/ws_cfg_regs.sv
rtl/core/ws_sym_gen.sv
rtl/core/ws_out_reg.sv
rtl/core/ws2812_symbol_encoder.sv
rtl/core/ws_checker.sv
tb/testbench.sv
